// File: hdl/pkr_pkg.sv
// Package for the multi-page shelf rectangle packer.
// Shared widths, reset values, result codes, register indexes and the
// command/status structs between the controller and the datapath.
`default_nettype none

package pkr_pkg;

  localparam int FW            = 13;               // pixel field width
  localparam int SW            = FW + 2;           // width of a grown sum
  localparam int STAT_W        = 2;
  localparam int PIDX_W        = 3;                // output page index width
  localparam int MAX_PAGES_DEF = 8;
  localparam logic [FW-1:0] ATLAS_RESET = FW'(1024);
  localparam logic [FW-1:0] FIELD_MAX   = {FW{1'b1}};

  // result codes
  localparam logic [STAT_W-1:0] ST_PLACED   = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERSIZE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

  // config register indexes
  localparam logic CFG_ATLAS_W = 1'b0;
  localparam logic CFG_ATLAS_H = 1'b1;

  // per-page shelf record
  typedef struct packed {
    logic [FW-1:0] cx;
    logic [FW-1:0] cy;
    logic [FW-1:0] rh;
  } pkr_rec_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch rectangle size
    logic open_first;  // open page 0, start scan there
    logic scan_start;  // start scan at page 0
    logic rd;          // read record of current page
    logic wrap;        // apply row wrap to record just read
    logic fit;         // write back record, place if it fits, else step page
    logic open_new;    // open a fresh page and place at (1,1)
    logic fail_big;    // result: larger than atlas
    logic fail_full;   // result: page limit reached
    logic emit;        // move pending result into output register
  } pkr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic oversize;
    logic no_pages;
    logic fits;
    logic more;
    logic at_limit;
  } pkr_sts_t;

  function automatic logic [FW-1:0] sat_fw(input logic [SW-1:0] v);
    sat_fw = (v > SW'(FIELD_MAX)) ? FIELD_MAX : v[FW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/pkr_ctrl.sv
// Sequencer of the shelf packer: page scan state machine and output valid.
// Depends on pkr_pkg for the command and status structs.
`default_nettype none

module pkr_ctrl
  import pkr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire pkr_sts_t sts,
  output pkr_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_READ, S_WRAP, S_FIT, S_NEW, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.oversize) begin
          cmd.fail_big = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts.no_pages) begin
          cmd.open_first = 1'b1;
          state_nxt      = S_READ;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = S_FIT;
      end
      S_FIT: begin
        cmd.fit = 1'b1;
        priority if (sts.fits) state_nxt = S_DONE;
        else if (sts.more)     state_nxt = S_READ;
        else                   state_nxt = S_NEW;
      end
      S_NEW: begin
        if (sts.at_limit) cmd.fail_full = 1'b1;
        else              cmd.open_new  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.emit | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/pkr_dp.sv
// Datapath of the shelf packer: config registers, page record memory,
// fit arithmetic, pending result and output register. Depends on pkr_pkg.
`default_nettype none

module pkr_dp
  import pkr_pkg::*;
#(
  parameter int MAX_PAGES = MAX_PAGES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_index,
  input  wire logic [FW-1:0]     cfg_data,
  input  wire logic [FW-1:0]     in_rect_width,
  input  wire logic [FW-1:0]     in_rect_height,
  output logic [STAT_W-1:0]      out_status,
  output logic [FW-1:0]          out_place_x,
  output logic [FW-1:0]          out_place_y,
  output logic [PIDX_W-1:0]      out_page_index,
  input  wire pkr_cmd_t          cmd,
  output pkr_sts_t               sts
);

  localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = $clog2(MAX_PAGES + 1);

  logic [FW-1:0] aw_r, ah_r;
  logic [FW-1:0] w_r, h_r;
  logic [PW-1:0] p_r;
  logic [CW-1:0] open_r;
  pkr_rec_t      mem_r [MAX_PAGES];
  pkr_rec_t      rd_r, wrk_r, wrk_nxt, placed;
  logic          mem_we;
  pkr_rec_t      mem_wdata;

  logic [STAT_W-1:0] res_stat_r, o_stat_r;
  logic [FW-1:0]     res_x_r, res_y_r, o_x_r, o_y_r;
  logic [PIDX_W-1:0] res_p_r, o_p_r;

  logic [SW-1:0] xsum, ysum, fsum, psum;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r <= ATLAS_RESET;
      ah_r <= ATLAS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ATLAS_W: aw_r <= cfg_data;
        CFG_ATLAS_H: ah_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // row wrap on the record just read
  assign xsum = SW'(rd_r.cx) + SW'(w_r) + SW'(1);
  assign ysum = SW'(rd_r.cy) + SW'(rd_r.rh) + SW'(1);
  always_comb begin
    wrk_nxt = rd_r;
    if (xsum >= SW'(aw_r)) begin
      wrk_nxt.cx = FW'(1);
      wrk_nxt.cy = sat_fw(ysum);
      wrk_nxt.rh = '0;
    end
  end

  // height test and placement on the wrapped record
  assign fsum = SW'(wrk_r.cy) + SW'(h_r) + SW'(1);
  assign psum = SW'(wrk_r.cx) + SW'(w_r) + SW'(1);
  always_comb begin
    placed.cx = sat_fw(psum);
    placed.cy = wrk_r.cy;
    placed.rh = (h_r > wrk_r.rh) ? h_r : wrk_r.rh;
  end

  assign sts.oversize = (w_r > aw_r) || (h_r > ah_r);
  assign sts.no_pages = (open_r == '0);
  assign sts.fits     = (fsum < SW'(ah_r));
  assign sts.more     = ((CW'(p_r) + CW'(1)) < open_r);
  assign sts.at_limit = (open_r == CW'(MAX_PAGES));

  // record write select
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = wrk_r;
    if (cmd.open_first) begin
      mem_we    = 1'b1;
      mem_wdata = '{cx: FW'(1), cy: FW'(1), rh: '0};
    end else if (cmd.fit) begin
      mem_we    = 1'b1;
      mem_wdata = sts.fits ? placed : wrk_r;
    end else if (cmd.open_new) begin
      mem_we    = 1'b1;
      mem_wdata = '{cx: sat_fw(SW'(w_r) + SW'(2)), cy: FW'(1), rh: h_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[p_r] <= mem_wdata;
    if (cmd.rd) rd_r <= mem_r[p_r];
    if (cmd.wrap) wrk_r <= wrk_nxt;
    if (cmd.load) begin
      w_r <= in_rect_width;
      h_r <= in_rect_height;
    end
  end

  // page counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
      p_r    <= '0;
    end else begin
      if (cmd.open_first) begin
        open_r <= CW'(1);
        p_r    <= '0;
      end
      if (cmd.scan_start) p_r <= '0;
      if (cmd.fit && !sts.fits) p_r <= p_r + PW'(1);
      if (cmd.open_new) open_r <= open_r + CW'(1);
    end
  end

  // pending result, then output register
  always_ff @(posedge clk) begin
    if (cmd.fail_big || cmd.fail_full) begin
      res_stat_r <= cmd.fail_big ? ST_OVERSIZE : ST_FULL;
      res_x_r    <= '0;
      res_y_r    <= '0;
      res_p_r    <= '0;
    end else if (cmd.fit && sts.fits) begin
      res_stat_r <= ST_PLACED;
      res_x_r    <= wrk_r.cx;
      res_y_r    <= wrk_r.cy;
      res_p_r    <= PIDX_W'(p_r);
    end else if (cmd.open_new) begin
      res_stat_r <= ST_PLACED;
      res_x_r    <= FW'(1);
      res_y_r    <= FW'(1);
      res_p_r    <= PIDX_W'(p_r);
    end
    if (cmd.emit) begin
      o_stat_r <= res_stat_r;
      o_x_r    <= res_x_r;
      o_y_r    <= res_y_r;
      o_p_r    <= res_p_r;
    end
  end

  assign out_status     = o_stat_r;
  assign out_place_x    = o_x_r;
  assign out_place_y    = o_y_r;
  assign out_page_index = o_p_r;

endmodule

`default_nettype wire

// File: hdl/multi_page_shelf_rect_packer_top.sv
// Top level of the multi-page shelf rectangle packer.
// Joins pkr_ctrl and pkr_dp; depends on pkr_pkg.
//
// Usage:
//  - Input channel (in_valid / in_stall): one beat is a rectangle size.
//    in_stall is high while an item is in work; one item at a time.
//  - Result channel (out_valid / out_stall): one beat per input beat with
//    status, position and page index. The result sits in an output register,
//    so a new item is taken while the previous result still waits.
//  - Config port: cfg_wr_en writes cfg_data to register cfg_index
//    (0 atlas width, 1 atlas height). Write only while idle.
//  - Sequence from accept to out_valid: a check state, then the done state
//    for an oversize rectangle; otherwise open pages are scanned from page 0
//    until one fits, and if none does a fresh page opens or the page limit is
//    hit before the done state.
//    Each page visited costs one read of the record memory, one wrap step
//    and one fit/write-back step; that per-page loop sets the rate.
//  - Next item: the next beat is taken in the cycle after the result moves
//    to the output register, so one item is in work at a time.
//  - A stalled result holds; the finished next item waits in its done state
//    until the output register frees.
//  - Reset: synchronous active-low; atlas size goes to 1024x1024, no pages
//    open. Page records are written when a page opens, so no clear sweep.
`default_nettype none

module multi_page_shelf_rect_packer_top
  import pkr_pkg::*;
#(
  parameter int MAX_PAGES = MAX_PAGES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [FW-1:0]     in_rect_width,
  input  wire logic [FW-1:0]     in_rect_height,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [STAT_W-1:0]      out_status,
  output logic [FW-1:0]          out_place_x,
  output logic [FW-1:0]          out_place_y,
  output logic [PIDX_W-1:0]      out_page_index,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_index,
  input  wire logic [FW-1:0]     cfg_data
);

  pkr_cmd_t cmd;
  pkr_sts_t sts;

  // sequencer
  pkr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // records, arithmetic, result registers
  pkr_dp #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .out_status     (out_status),
    .out_place_x    (out_place_x),
    .out_place_y    (out_place_y),
    .out_page_index (out_page_index),
    .cmd            (cmd),
    .sts            (sts)
  );

  // failed placements carry zero position and page
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_PLACED) |->
      (out_place_x == '0) && (out_place_y == '0) && (out_page_index == '0))
    else $error("failure result with nonzero position");

  // an accepted beat blocks the input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // only defined result codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_PLACED) || (out_status == ST_OVERSIZE) ||
                  (out_status == ST_FULL))
    else $error("undefined status code");

  // the controller never issues two record commands at once
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.open_first, cmd.fit, cmd.open_new, cmd.fail_big, cmd.fail_full}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// File: sim/multi_page_shelf_rect_packer_top_tb.sv
// Testbench for multi_page_shelf_rect_packer_top: a directed table, then random phases
// at several atlas sizes, beats checked against typed rows or a shelf predictor.
// Depends on pkr_pkg and the packer RTL only.
`timescale 1ns / 100ps

module multi_page_shelf_rect_packer_top_tb;
  import pkr_pkg::*;

  localparam int PAGES = MAX_PAGES_DEF;

  // one result beat
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FW-1:0]     x;
    logic [FW-1:0]     y;
    logic [PIDX_W-1:0] page;
  } placement_t;

  // directed table row: a rectangle, or a new atlas size
  typedef enum logic {ROW_RECT, ROW_ATLAS} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [FW-1:0] a;     // width
    logic [FW-1:0] b;     // height
    bit         typed;    // expected result written into the row
    placement_t want;
  } plan_row_t;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_CHOKE, RX_COMB} rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [FW-1:0]     in_rect_width;
  logic [FW-1:0]     in_rect_height;
  logic              out_valid;
  logic              out_stall;
  logic [STAT_W-1:0] out_status;
  logic [FW-1:0]     out_place_x;
  logic [FW-1:0]     out_place_y;
  logic [PIDX_W-1:0] out_page_index;
  logic              cfg_wr_en;
  logic              cfg_index;
  logic [FW-1:0]     cfg_data;

  multi_page_shelf_rect_packer_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_place_x    (out_place_x),
    .out_place_y    (out_place_y),
    .out_page_index (out_page_index),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: shelf cursor per page, open page count, atlas size.
  // Entries of pages not yet opened are never read.
  // ---------------------------------------------------------------------------
  logic [FW-1:0] shelf_x  [PAGES];
  logic [FW-1:0] shelf_y  [PAGES];
  logic [FW-1:0] shelf_rh [PAGES];
  int            pages_used;
  logic [FW-1:0] atlas_w;
  logic [FW-1:0] atlas_h;

  placement_t    placements_due[$];   // expected beats, oldest first
  plan_row_t     plan[$];
  int            mismatch_cnt;

  // sender burst shaping
  int            burst_left;
  int            gap_left;

  // receiver stall shaping
  rx_mode_t      rx_mode;
  int            rx_run;

  placement_t    seen;
  placement_t    oldest;

  // cursor arithmetic is done in int, so nothing is lost before the clamp
  function automatic logic [FW-1:0] sat_pix(input int v);
    return (v > int'(FIELD_MAX)) ? FIELD_MAX : v[FW-1:0];
  endfunction

  function automatic placement_t place_rect(input logic [FW-1:0] w, input logic [FW-1:0] h);
    placement_t r;
    bit         placed;
    int         p;
    r      = '{status: ST_FULL, x: '0, y: '0, page: '0};
    placed = 1'b0;
    if (w > atlas_w || h > atlas_h) begin
      r.status = ST_OVERSIZE;
    end else begin
      if (pages_used == 0) begin
        shelf_x[0]  = 1;
        shelf_y[0]  = 1;
        shelf_rh[0] = 0;
        pages_used  = 1;
      end
      // scan open pages in order; a row wrap sticks even if the page is skipped
      for (p = 0; p <= PAGES; p++) begin
        if (!placed && p < pages_used) begin
          if (int'(shelf_x[p]) + int'(w) + 1 >= int'(atlas_w)) begin
            shelf_x[p]  = 1;
            shelf_y[p]  = sat_pix(int'(shelf_y[p]) + int'(shelf_rh[p]) + 1);
            shelf_rh[p] = 0;
          end
          if (int'(shelf_y[p]) + int'(h) + 1 < int'(atlas_h)) begin
            placed = 1'b1;
            r = '{status: ST_PLACED, x: shelf_x[p], y: shelf_y[p], page: p[PIDX_W-1:0]};
            shelf_x[p] = sat_pix(int'(shelf_x[p]) + int'(w) + 1);
            if (h > shelf_rh[p])
              shelf_rh[p] = h;
          end
        end
      end
      // fresh page: top-left corner, no fit test
      if (!placed && pages_used < PAGES) begin
        p = pages_used;
        r = '{status: ST_PLACED, x: FW'(1), y: FW'(1), page: p[PIDX_W-1:0]};
        shelf_x[p]  = sat_pix(1 + int'(w) + 1);
        shelf_y[p]  = 1;
        shelf_rh[p] = h;
        pages_used  = p + 1;
      end
    end
    return r;
  endfunction

  // random side: mostly well inside the atlas, some at and past its edge
  function automatic logic [FW-1:0] pick_side(input logic [FW-1:0] lim);
    int v;
    case ($urandom_range(0, 19))
      0:          v = $urandom_range(0, int'(FIELD_MAX));
      1:          v = lim;
      2:          v = lim + 1;
      3:          v = 0;
      4, 5, 6, 7: v = $urandom_range(0, lim);
      default:    v = $urandom_range(1, (lim > 4) ? lim / 4 : 1);
    endcase
    return v[FW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout covers the slowest run (8-page scan, long stalls, gaps)
  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stretches of free flow, coin-flip stalls, heavy choking and a
  // fixed comb, each for a run of random length.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_run == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_run  = $urandom_range(20, 200);
    end
    rx_run = rx_run - 1;
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_COIN:  out_stall <= ($urandom_range(0, 1) == 0);
      RX_CHOKE: out_stall <= ($urandom_range(0, 7) != 0);
      default:  out_stall <= ((rx_run % 5) < 2);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input placement_t want,
                               input placement_t got);
    if (mismatch_cnt < 10)
      $display("%0t %s: want st=%0d x=%0d y=%0d pg=%0d, got st=%0d x=%0d y=%0d pg=%0d",
               $realtime, what, want.status, want.x, want.y, want.page,
               got.status, got.x, got.y, got.page);
    mismatch_cnt = mismatch_cnt + 1;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = '{status: out_status, x: out_place_x, y: out_place_y, page: out_page_index};
      if (placements_due.size() == 0) begin
        note_mismatch("unexpected beat", '0, seen);
      end else begin
        oldest = placements_due.pop_front();
        if (seen !== oldest)
          note_mismatch("result mismatch", oldest, seen);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Called and returns at a falling edge. Valid stays up across
  // back-to-back beats; a gap of random length drops it between bursts.
  // ---------------------------------------------------------------------------
  task automatic send_rect(input logic [FW-1:0] w, input logic [FW-1:0] h,
                           input bit typed, input placement_t want);
    placement_t predicted;
    placement_t due;
    while (gap_left > 0) begin
      in_valid <= 1'b0;
      @(negedge clk);
      gap_left = gap_left - 1;
    end
    in_valid       <= 1'b1;
    in_rect_width  <= w;
    in_rect_height <= h;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    // beat taken at this edge; predictor always runs to keep its state
    predicted = place_rect(w, h);
    due = typed ? want : predicted;
    placements_due = {placements_due, due};
    @(negedge clk);
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
    end
  endtask

  // Atlas size change: only with nothing in flight. Every beat has a result,
  // so an empty expectation queue means the block is idle.
  task automatic write_atlas(input logic [FW-1:0] w, input logic [FW-1:0] h);
    in_valid <= 1'b0;
    while (placements_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ATLAS_W;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= CFG_ATLAS_H;
    cfg_data  <= h;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    atlas_w = w;
    atlas_h = h;
  endtask

  task automatic add_rect(input logic [FW-1:0] w, input logic [FW-1:0] h);
    plan_row_t row;
    row  = '{kind: ROW_RECT, a: w, b: h, typed: 1'b0, want: '0};
    plan = {plan, row};
  endtask

  task automatic add_rect_typed(input logic [FW-1:0] w, input logic [FW-1:0] h,
                                input logic [STAT_W-1:0] st, input logic [FW-1:0] x,
                                input logic [FW-1:0] y, input logic [PIDX_W-1:0] pg);
    plan_row_t row;
    row  = '{kind: ROW_RECT, a: w, b: h, typed: 1'b1,
             want: '{status: st, x: x, y: y, page: pg}};
    plan = {plan, row};
  endtask

  task automatic add_atlas(input logic [FW-1:0] w, input logic [FW-1:0] h);
    plan_row_t row;
    row  = '{kind: ROW_ATLAS, a: w, b: h, typed: 1'b0, want: '0};
    plan = {plan, row};
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int            ph;
    int            k;
    int            n_items;
    logic [FW-1:0] aw;
    logic [FW-1:0] ah;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_rect_width  = '0;
    in_rect_height = '0;
    out_stall      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_ATLAS_W;
    cfg_data       = '0;
    mismatch_cnt   = 0;
    pages_used     = 0;
    atlas_w        = ATLAS_RESET;
    atlas_h        = ATLAS_RESET;
    burst_left     = $urandom_range(1, 40);
    gap_left       = 0;
    rx_mode        = RX_FREE;
    rx_run         = 0;

    // Directed table, at the reset atlas size of 1024 x 1024 first.
    // First request opens page 0 and lands at its top-left corner.
    add_rect_typed(10, 20, ST_PLACED, 1, 1, 0);
    // larger than the atlas in either side, and all-ones sides
    add_rect_typed(1025, 5, ST_OVERSIZE, 0, 0, 0);
    add_rect_typed(5, 1025, ST_OVERSIZE, 0, 0, 0);
    add_rect_typed(8191, 8191, ST_OVERSIZE, 0, 0, 0);
    // zero size, then exactly atlas wide (forces a row wrap)
    add_rect(0, 0);
    add_rect(1024, 1);
    // full atlas height: page 0 wraps, is skipped, page 1 opens
    add_rect(1, 1024);
    // tall rectangles skip every open page and open pages 2..7
    for (k = 0; k < PAGES - 2; k++)
      add_rect(10, 1022);
    // no page fits and no page left
    add_rect_typed(10, 1022, ST_FULL, 0, 0, 0);
    // 4096 x 4096 atlas with a rectangle of the same size, then one pixel over
    add_atlas(4096, 4096);
    add_rect_typed(4096, 4096, ST_FULL, 0, 0, 0);
    add_rect_typed(4097, 1, ST_OVERSIZE, 0, 0, 0);
    add_rect(100, 100);
    // all-ones atlas: a full-width rectangle saturates the row position
    add_atlas(8191, 8191);
    add_rect(8191, 8191);
    add_rect(8191, 1);
    add_rect(1, 1);
    // 1 x 1 atlas
    add_atlas(1, 1);
    add_rect(1, 1);
    add_rect_typed(2, 1, ST_OVERSIZE, 0, 0, 0);
    add_rect(0, 0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_ATLAS)
        write_atlas(plan[i].a, plan[i].b);
      else
        send_rect(plan[i].a, plan[i].b, plan[i].typed, plan[i].want);
    end

    // Random phases. Pages stay open for the rest of the run, so the atlas
    // size swings between roomy and cramped to keep the scan busy.
    for (ph = 0; ph < 10; ph++) begin
      n_items = 125;
      case (ph)
        0: begin aw = 8191; ah = 8191; end
        1: begin aw = 4096; ah = 4096; end
        2: begin aw = 1024; ah = 1024; end
        3: begin aw = 300;  ah = 4096; end
        4: begin aw = 4096; ah = 300;  end
        5: begin aw = 64;   ah = 64;   end
        6: begin aw = 0;    ah = 0;    n_items = 20; end
        7: begin
          aw = FW'($urandom_range(1, int'(FIELD_MAX)));
          ah = FW'($urandom_range(1, int'(FIELD_MAX)));
        end
        8: begin aw = 128;  ah = 2000; end
        default: begin aw = 2048; ah = 2048; end
      endcase
      write_atlas(aw, ah);
      for (k = 0; k < n_items; k++)
        send_rect(pick_side(aw), pick_side(ah), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (placements_due.size() != 0)
      @(posedge clk);
    // longest scan plus the output register
    repeat (40) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hdl/pkr_pkg.sv
hdl/pkr_ctrl.sv
hdl/pkr_dp.sv
hdl/multi_page_shelf_rect_packer_top.sv
sim/multi_page_shelf_rect_packer_top_tb.sv
